// ===== design/b64d_pkg.sv =====
// b64d_pkg: types, result codes and the character map of the base64 decoder.
// No dependencies.
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // mask[3]: high byte, mask[2]: middle byte, mask[1]: low byte, mask[0]: status
    typedef struct packed {
        logic [23:0] bytes;
        logic [3:0]  mask;
        logic        err;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== design/b64d_front.sv =====
// b64d_front: classifies each character, gathers groups of four and builds
// one command word per item that yields results. Depends on b64d_pkg.
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    input  logic             i_is_last,
    output logic             o_cmd_valid,
    output b64d_pkg::t_cmd   o_cmd
);

    logic [1:0]  r_pos,  n_pos;
    logic [17:0] r_acc,  n_acc;
    logic        r_tpad, n_tpad;
    logic        r_err,  n_err;

    b64d_pkg::t_sextet sx;
    logic              pad;
    logic [23:0]       grp;
    b64d_pkg::t_cmd    cmd;

    always_comb begin
        sx     = b64d_pkg::sextet_of(i_char_code);
        pad    = (i_char_code == b64d_pkg::PAD_CHAR);
        n_err  = r_err;
        if (pad) begin
            if (r_pos < 2'd2) n_err = 1'b1;
        end else if (!sx.ok) begin
            n_err = 1'b1;
        end
        grp       = {r_acc, (pad || !sx.ok) ? 6'd0 : sx.val};
        cmd.bytes = grp;
        cmd.mask  = '0;
        cmd.err   = 1'b0;
        n_acc     = r_acc;
        n_tpad    = r_tpad;
        n_pos     = r_pos;
        if (r_pos != 2'd3) begin
            n_acc = grp[17:0];
            if (r_pos == 2'd2) n_tpad = pad;
            n_pos = r_pos + 2'd1;
        end else begin
            if (!n_err) begin
                cmd.mask[3] = 1'b1;
                cmd.mask[2] = !r_tpad;
                cmd.mask[1] = !pad;
            end
            n_pos  = '0;
            n_acc  = '0;
            n_tpad = 1'b0;
        end
        if (i_is_last) begin
            cmd.mask[0] = 1'b1;
            cmd.err     = n_err || (n_pos != 2'd0);
            n_pos       = '0;
            n_acc       = '0;
            n_tpad      = 1'b0;
            n_err       = 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_accept && (cmd.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_tpad <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_tpad <= n_tpad;
            r_err  <= n_err;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_is_last |=> r_pos == 2'd0 && !r_err && !r_tpad)
        else $error("state not cleared after end of string");

endmodule

// ===== design/b64d_cmd_fifo.sv =====
// b64d_cmd_fifo: short queue of command words between front and back.
// Depends on b64d_pkg.
module b64d_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64d_pkg::t_cmd   i_data,
    output logic             o_full,
    input  logic             i_pop,
    output b64d_pkg::t_cmd   o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("command queue count out of range");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty && !i_push |=> o_empty)
        else $error("command queue filled without a push");

endmodule

// ===== design/b64d_back.sv =====
// b64d_back: unpacks command words into single result words, one per cycle
// while the receiver keeps taking them, behind an output register. Depends on b64d_pkg.
module b64d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  b64d_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic             o_last_of_run
);

    b64d_pkg::t_cmd r_cur;
    logic           r_cur_valid;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic [1:0]     r_kind;
    logic           r_last;

    logic       slot_free, emit, done;
    logic [3:0] rest;
    logic [7:0] n_byte;
    logic [1:0] n_kind;

    always_comb begin
        rest   = r_cur.mask;
        n_byte = '0;
        n_kind = b64d_pkg::KIND_DATA;
        priority if (r_cur.mask[3]) begin
            n_byte  = r_cur.bytes[23:16];
            rest[3] = 1'b0;
        end else if (r_cur.mask[2]) begin
            n_byte  = r_cur.bytes[15:8];
            rest[2] = 1'b0;
        end else if (r_cur.mask[1]) begin
            n_byte  = r_cur.bytes[7:0];
            rest[1] = 1'b0;
        end else begin
            n_kind  = r_cur.err ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
            rest[0] = 1'b0;
        end
    end

    assign slot_free = !r_out_valid || i_pop;
    assign emit      = r_cur_valid && slot_free;
    assign done      = emit && (rest == '0);
    assign o_cmd_pop = (!r_cur_valid || done) && !i_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_cur       <= i_cmd;
                r_cur_valid <= 1'b1;
            end else if (done) begin
                r_cur_valid <= 1'b0;
            end else if (emit) begin
                r_cur.mask  <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= n_byte;
                r_kind      <= n_kind;
                r_last      <= (rest == '0);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_kind        = r_kind;
    assign o_last_of_run = r_last;

    a_cur_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_cur.mask != '0)
        else $error("held command word has nothing left to emit");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != b64d_pkg::KIND_DATA |-> r_last && r_out_byte == '0)
        else $error("status word not last of its run");

endmodule

// ===== design/base64_stream_decoder.sv =====
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_cmd_fifo, b64d_back.
//
// Input channel: one character per word on i_char_code, i_is_last marks the
// final character of a string. A word is taken when i_push is high and
// o_full is low. Result channel: while o_empty is low the oldest result sits
// on o_out_byte / o_kind / o_last_of_run; i_pop takes it.
// A completed group with no error yields one to three data words (kind
// data); the character marked last adds one status word (ok or error) that
// ends the string; o_last_of_run flags the final result caused by one
// character. A character's first result passes the command queue, the
// command register and the output register. Throughput: one character per
// cycle in while o_full is low and one result word per cycle out while i_pop
// is high; the queue (CMD_DEPTH words) absorbs bursts of up to four results
// per character. Reset (synchronous, active low) clears the group state, the
// queue and the output register. When the receiver stalls the output
// register holds, the back end stops, the queue fills and o_full rises.
module base64_stream_decoder #(
    parameter int CMD_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last_of_run
);

    logic           accept;
    logic           cmd_valid;
    b64d_pkg::t_cmd cmd_in;
    b64d_pkg::t_cmd cmd_out;
    logic           q_full, q_empty, q_pop;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    b64d_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (cmd_out),
        .o_empty (q_empty)
    );

    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (q_empty),
        .i_cmd         (cmd_out),
        .o_cmd_pop     (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== dv/tb_base64_stream_decoder.sv =====
// tb_base64_stream_decoder: self-checking bench for the streaming base64 decoder.
// Drives characters through a queue-style port, predicts data and status words
// in step with accepted characters and checks every popped word. Needs b64d_pkg.
`timescale 1ns / 100ps

module tb_base64_stream_decoder;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 297;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_char_word;

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic       run_end;
    } t_decoded;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       is_last = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    t_char_word pending_chars[$];
    t_decoded   awaited_words[$];

    // decoder state mirror
    logic [1:0]  grp_pos = '0;
    logic [17:0] sextet_acc = '0;
    logic        third_pad = 1'b0;
    logic        err_flag = 1'b0;

    logic        char_taken = 1'b0;
    int unsigned chars_taken = 0;
    int unsigned cycle_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned data_words = 0;
    int unsigned ok_words = 0;
    int unsigned err_words = 0;
    int unsigned hold_cnt = 0;
    logic        hold_done = 1'b0;
    logic        calm;

    assign calm = (chars_taken >= 200) && (chars_taken < 260);

    base64_stream_decoder dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_char_code   (char_code),
        .i_is_last     (is_last),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (out_byte),
        .o_kind        (kind),
        .o_last_of_run (last_of_run)
    );

    always #2 clk = ~clk;

    function automatic int sextet_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
        if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
        if (c == 8'h2B) return 62;
        if (c == 8'h2F) return 63;
        return -1;
    endfunction

    function automatic logic [7:0] alphabet_char(input int unsigned idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        if (idx == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic last);
        int          sv;
        logic        pad;
        logic [5:0]  val;
        logic [23:0] grp;
        t_decoded    burst[$];
        t_decoded    w;
        pad = (c == b64d_pkg::PAD_CHAR);
        sv  = sextet_value(c);
        val = '0;
        if (pad) begin
            if (grp_pos < 2) err_flag = 1'b1;
        end else if (sv < 0) begin
            err_flag = 1'b1;
        end else begin
            val = 6'(sv);
        end
        if (grp_pos != 2'd3) begin
            sextet_acc = {sextet_acc[11:0], val};
            if (grp_pos == 2'd2) third_pad = pad;
            grp_pos = grp_pos + 2'd1;
        end else begin
            grp = {sextet_acc, val};
            w.kind = b64d_pkg::KIND_DATA;
            w.run_end = 1'b0;
            if (!err_flag) begin
                w.data = grp[23:16];
                burst.push_back(w);
                if (!third_pad) begin
                    w.data = grp[15:8];
                    burst.push_back(w);
                end
                if (!pad) begin
                    w.data = grp[7:0];
                    burst.push_back(w);
                end
            end
            grp_pos = '0;
            sextet_acc = '0;
            third_pad = 1'b0;
        end
        if (last) begin
            w.data = 8'h00;
            w.kind = (err_flag || grp_pos != 2'd0) ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
            w.run_end = 1'b0;
            burst.push_back(w);
            grp_pos = '0;
            sextet_acc = '0;
            third_pad = 1'b0;
            err_flag = 1'b0;
        end
        if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
        foreach (burst[i]) awaited_words.push_back(burst[i]);
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic add_word(input logic [7:0] c, input logic last);
        t_char_word cw;
        cw.code = c;
        cw.last = last;
        pending_chars.push_back(cw);
    endtask

    task automatic queue_text(input string s, input logic end_string);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], end_string && (i == s.len() - 1));
    endtask

    // mostly well-formed strings; some with a stray byte, a misplaced pad,
    // a dropped or an extra character
    task automatic add_random_string(output int unsigned len);
        int unsigned n_groups;
        int unsigned pads;
        int unsigned mode;
        logic [7:0]  text[$];
        n_groups = $urandom_range(4, 1);
        for (int i = 0; i < n_groups * 4; i++) text.push_back(alphabet_char($urandom_range(63)));
        pads = $urandom_range(2);
        if (pads >= 1) text[text.size() - 1] = b64d_pkg::PAD_CHAR;
        if (pads == 2) text[text.size() - 2] = b64d_pkg::PAD_CHAR;
        mode = $urandom_range(99);
        if (mode < 10)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        else if (mode < 17)
            text[$urandom_range(text.size() - 1)] = b64d_pkg::PAD_CHAR;
        else if (mode < 24 && text.size() > 1)
            void'(text.pop_back());
        else if (mode < 29)
            text.push_back(alphabet_char($urandom_range(63)));
        foreach (text[i]) add_word(text[i], i == text.size() - 1);
        len = text.size();
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || push || awaited_words.size() != 0)
            @(posedge clk);
    endtask

    // input side
    always @(negedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else if (!push || char_taken) begin
            if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                push      <= 1'b1;
                char_code <= pending_chars[0].code;
                is_last   <= pending_chars[0].last;
                void'(pending_chars.pop_front());
            end else begin
                push <= 1'b0;
            end
        end
    end

    // output side, with one long hold-off to back the decoder up
    always @(negedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            pop <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && chars_taken >= 80) begin
            pop <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            pop <= calm || ($urandom_range(99) >= 35);
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        t_decoded want;
        cycle_cnt++;
        char_taken = rst_n && push && !full;
        if (char_taken) begin
            chars_taken++;
            decode_char(char_code, is_last);
        end
        if (rst_n && pop && !empty) begin
            if (awaited_words.size() == 0) begin
                note_failure($sformatf("unexpected word byte=%02h kind=%0d last=%0b",
                    out_byte, kind, last_of_run));
            end else begin
                want = awaited_words.pop_front();
                if (out_byte !== want.data || kind !== want.kind
                        || last_of_run !== want.run_end)
                    note_failure($sformatf(
                        "word mismatch: exp byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                        want.data, want.kind, want.run_end, out_byte, kind, last_of_run));
                if (want.kind == b64d_pkg::KIND_DATA) data_words++;
                else if (want.kind == b64d_pkg::KIND_OK) ok_words++;
                else err_words++;
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned random_chars;
        int unsigned len;
        logic        mid_drain;
        random_chars = 0;
        mid_drain = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        queue_text("TWFu", 1'b0);
        queue_text("AB=C", 1'b0);
        queue_text("//==", 1'b1);
        queue_text("A=AA", 1'b1);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        queue_text("z9", 1'b1);
        queue_text("AB", 1'b1);
        queue_text("=", 1'b1);
        wait_drained();

        while (random_chars < RANDOM_CHARS) begin
            add_random_string(len);
            random_chars += len;
            if (!mid_drain && random_chars >= RANDOM_CHARS / 2) begin
                wait_drained();
                mid_drain = 1'b1;
            end
        end
        wait_drained();
        repeat (10) @(negedge clk);

        if (awaited_words.size() != 0)
            note_failure($sformatf("%0d words never arrived", awaited_words.size()));
        $display("Run: %0d characters in, %0d data bytes, %0d good and %0d bad string ends checked",
            chars_taken, data_words, ok_words, err_words);
        $display("Mismatches: %0d over %0d cycles", mismatches, cycle_cnt);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_cmd_fifo.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
dv/tb_base64_stream_decoder.sv
